@@ hdl/pen_pkg.sv @@
// ----------------------------------------------------------------------------
// pen_pkg: shared types and helpers for the percent escape normalizer
// Entry and operation types, queue sizing, and the byte classification and
// window decode functions used by the front and back halves.
// ----------------------------------------------------------------------------
package pen_pkg;

  localparam int unsigned OpsMax     = 3;
  localparam int unsigned OpIdxW     = $clog2(OpsMax);
  localparam int unsigned MaxBytes   = 5;
  localparam int unsigned SentW      = $clog2(MaxBytes);
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [7:0] ChPct = 8'h25;

  typedef enum logic {
    OP_PLAIN = 1'b0,
    OP_ESC   = 1'b1
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] value;
  } op_t;

  typedef struct packed {
    op_t [OpsMax-1:0]  ops;
    logic [OpIdxW-1:0] op_cnt;
    logic              last;
  } entry_t;

  typedef struct packed {
    entry_t          entry;
    logic [1:0]      hold_cnt;
    logic [1:0][7:0] hold;
  } front_res_t;

  function automatic logic is_unreserved(input logic [7:0] v);
    return (v >= 8'h61 && v <= 8'h7A) || (v >= 8'h41 && v <= 8'h5A) ||
           (v >= 8'h30 && v <= 8'h39) || v == 8'h2D || v == 8'h2E ||
           v == 8'h5F || v == 8'h7E;
  endfunction

  function automatic logic is_delim(input logic [7:0] v);
    logic r;
    case (v)
      8'h3A, 8'h2F, 8'h3F, 8'h23, 8'h5B, 8'h5D,
      8'h40, 8'h21, 8'h24, 8'h26, 8'h27, 8'h28,
      8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h3B, 8'h3D: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_hex(input logic [7:0] v);
    return (v >= 8'h30 && v <= 8'h39) || (v >= 8'h41 && v <= 8'h46) ||
           (v >= 8'h61 && v <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] v);
    logic [3:0] r;
    if (v <= 8'h39) begin
      r = v[3:0];
    end else begin
      r = v[3:0] + 4'd9;
    end
    return r;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = 8'h30 + {4'h0, d};
    end else begin
      r = 8'h37 + {4'h0, d};
    end
    return r;
  endfunction

  function automatic op_t make_op(input logic [7:0] v, input logic plain);
    op_t o;
    o.kind  = plain ? OP_PLAIN : OP_ESC;
    o.value = v;
    return o;
  endfunction

  // The window holds the held bytes followed by the new byte, oldest in w[0].
  function automatic front_res_t classify(input logic [2:0][7:0] w, input logic [1:0] n,
                                          input logic last);
    front_res_t r;
    logic [1:0] pos;
    logic       stop;
    logic       full;
    logic [7:0] c;
    logic [7:0] v;
    logic [1:0] rem;
    r    = '0;
    pos  = '0;
    stop = 1'b0;
    for (int s = 0; s < OpsMax; s++) begin
      if (!stop && (pos < n)) begin
        c    = w[pos];
        full = (pos == 2'd0) && (n == 2'd3);
        if (c == ChPct) begin
          if (full && is_hex(w[1]) && is_hex(w[2])) begin
            v = {hex_val(w[1]), hex_val(w[2])};
            r.entry.ops[r.entry.op_cnt] = make_op(v, is_unreserved(v));
            r.entry.op_cnt = r.entry.op_cnt + 1'b1;
            pos = 2'd3;
          end else if (!full && !last) begin
            stop = 1'b1;
          end else begin
            r.entry.ops[r.entry.op_cnt] = make_op(ChPct, 1'b1);
            r.entry.op_cnt = r.entry.op_cnt + 1'b1;
            pos = pos + 2'd1;
          end
        end else begin
          r.entry.ops[r.entry.op_cnt] = make_op(c, is_delim(c) || is_unreserved(c));
          r.entry.op_cnt = r.entry.op_cnt + 1'b1;
          pos = pos + 2'd1;
        end
      end
    end
    rem        = n - pos;
    r.hold_cnt = rem;
    if (rem != 2'd0) begin
      r.hold[0] = w[pos];
    end
    if (rem == 2'd2) begin
      r.hold[1] = w[pos + 2'd1];
    end
    r.entry.last = last;
    return r;
  endfunction

endpackage

@@ hdl/pen_front.sv @@
// ----------------------------------------------------------------------------
// pen_front: input side of the percent escape normalizer
// Holds pending escape bytes, judges the window on each accepted beat and
// pushes a list of plain and escape operations into the queue.
// ----------------------------------------------------------------------------
module pen_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_byte,
  input  logic            in_is_last,
  input  logic            q_full,
  output logic            push,
  output pen_pkg::entry_t push_entry
);
  import pen_pkg::*;

  logic [1:0]      held_count_r, held_count_nxt;
  logic [1:0][7:0] held_r, held_nxt;
  logic [2:0][7:0] win;
  logic [1:0]      win_n;
  front_res_t      res;
  logic            acc;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;
  assign win_n    = held_count_r + 2'd1;

  always_comb begin
    win = '0;
    case (held_count_r)
      2'd0: begin
        win[0] = in_byte;
      end
      2'd1: begin
        win[0] = held_r[0];
        win[1] = in_byte;
      end
      default: begin
        win[0] = held_r[0];
        win[1] = held_r[1];
        win[2] = in_byte;
      end
    endcase
  end

  assign res        = classify(win, win_n, in_is_last);
  assign push       = acc && (res.entry.op_cnt != '0);
  assign push_entry = res.entry;

  always_comb begin
    held_count_nxt = held_count_r;
    held_nxt       = held_r;
    if (acc) begin
      held_count_nxt = res.hold_cnt;
      held_nxt       = res.hold;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_count_r <= '0;
    end else begin
      held_count_r <= held_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

endmodule

@@ hdl/pen_queue.sv @@
// ----------------------------------------------------------------------------
// pen_queue: operation queue between front and back
// A small register FIFO of decoded entries, one push and one pop per cycle.
// ----------------------------------------------------------------------------
module pen_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pen_pkg::entry_t push_entry,
  input  logic            pop,
  output logic            full,
  output logic            q_valid,
  output pen_pkg::entry_t q_entry
);
  import pen_pkg::*;

  entry_t             mem_r [QueueDepth];
  logic [QPtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == QCntW'(QueueDepth));
  assign q_valid = (cnt_r != '0);
  assign q_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ hdl/pen_back.sv @@
// ----------------------------------------------------------------------------
// pen_back: output side of the percent escape normalizer
// Expands queued operations into single bytes, one per cycle unless stalled,
// at most five bytes per input beat, and drives the registered result channel.
// ----------------------------------------------------------------------------
module pen_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  pen_pkg::entry_t q_entry,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            out_last
);
  import pen_pkg::*;

  logic              cur_valid_r, cur_valid_nxt;
  entry_t            cur_r, cur_nxt;
  logic [OpIdxW-1:0] op_idx_r, op_idx_nxt;
  logic [1:0]        ph_r, ph_nxt;
  logic [SentW-1:0]  sent_r, sent_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;
  op_t               op;
  logic [7:0]        cur_byte;
  logic              op_end;
  logic              entry_end;
  logic              load;

  assign op = cur_r.ops[op_idx_r];

  always_comb begin
    cur_byte = op.value;
    op_end   = 1'b1;
    case (op.kind)
      OP_PLAIN: begin
        cur_byte = op.value;
        op_end   = 1'b1;
      end
      OP_ESC: begin
        op_end = (ph_r == 2'd2);
        case (ph_r)
          2'd0:    cur_byte = ChPct;
          2'd1:    cur_byte = hex_char(op.value[7:4]);
          default: cur_byte = hex_char(op.value[3:0]);
        endcase
      end
      default: begin
        cur_byte = op.value;
        op_end   = 1'b1;
      end
    endcase
  end

  assign entry_end = (op_end && (op_idx_r == cur_r.op_cnt - 1'b1)) ||
                     (sent_r == SentW'(MaxBytes - 1));
  assign load      = cur_valid_r && (!out_valid_r || !out_stall);
  assign pop       = q_valid && (!cur_valid_r || (load && entry_end));

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_nxt       = cur_r;
    op_idx_nxt    = op_idx_r;
    ph_nxt        = ph_r;
    sent_nxt      = sent_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = cur_byte;
      out_last_nxt  = cur_r.last && entry_end;
      if (entry_end) begin
        cur_valid_nxt = 1'b0;
        op_idx_nxt    = '0;
        ph_nxt        = '0;
        sent_nxt      = '0;
      end else if (op_end) begin
        op_idx_nxt = op_idx_r + 1'b1;
        ph_nxt     = '0;
        sent_nxt   = sent_r + 1'b1;
      end else begin
        ph_nxt   = ph_r + 2'd1;
        sent_nxt = sent_r + 1'b1;
      end
    end
    if (pop) begin
      cur_valid_nxt = 1'b1;
      cur_nxt       = q_entry;
      op_idx_nxt    = '0;
      ph_nxt        = '0;
      sent_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      op_idx_r    <= '0;
      ph_r        <= '0;
      sent_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      op_idx_r    <= op_idx_nxt;
      ph_r        <= ph_nxt;
      sent_r      <= sent_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

@@ hdl/percent_escape_normalizer.sv @@
// ----------------------------------------------------------------------------
// percent_escape_normalizer: URI component percent-escape normalizer
// Decodes escapes of unreserved characters, uppercases the remaining escapes
// and escapes bytes that are neither unreserved nor delimiters.
//
//   Channel  Ports                                   Direction
//   in       in_valid, in_stall, in_byte, in_is_last  sink, one raw byte
//   out      out_valid, out_stall, out_byte, out_last source, one result byte
//
// Each input beat yields zero to five output beats, one per cycle from the
// output register while out_stall is low. Its first byte passes through the
// operation queue, the current-entry register and the output register. The
// input side stalls only while the two-entry operation queue is full. Reset
// is synchronous; it empties the queue, the output register and the held
// escape bytes, and needs no clearing pass.
// ----------------------------------------------------------------------------
module percent_escape_normalizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_is_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);
  import pen_pkg::*;

  logic   q_full;
  logic   push;
  entry_t push_entry;
  logic   pop;
  logic   q_valid;
  entry_t q_entry;

  pen_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .in_is_last (in_is_last),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  pen_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .q_valid    (q_valid),
    .q_entry    (q_entry)
  );

  pen_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

@@ hdl/pen_checker.sv @@
// ----------------------------------------------------------------------------
// pen_checker: port-level checks for the percent escape normalizer
// Watches reset behavior, the input and output hold rules and the output
// character set.
// ----------------------------------------------------------------------------
module pen_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_byte,
  input logic       in_is_last,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_last
);
  import pen_pkg::*;

  a_reset_out_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output beat shown right after reset");

  a_reset_in_open: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
      in_valid && in_stall |=> in_valid && $stable(in_byte) && $stable(in_is_last))
    else $error("stalled input beat changed or dropped");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled output beat changed or dropped");

  a_out_charset: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> (is_unreserved(out_byte) || is_delim(out_byte) || out_byte == ChPct))
    else $error("output byte outside the normalized character set");

endmodule

bind percent_escape_normalizer pen_checker u_pen_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .in_byte    (in_byte),
  .in_is_last (in_is_last),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_byte   (out_byte),
  .out_last   (out_last)
);

@@ sim/tb_percent_escape_normalizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_percent_escape_normalizer: self-checking bench for the escape normalizer
// Feeds URI components byte by byte and predicts the normalized byte stream:
// decoded escapes of unreserved characters, uppercased remaining escapes and
// escaped bytes that are neither unreserved nor delimiters. Directed cases
// come first, then a receiver hold-off, drained pauses and random components
// with bursty input and patterned output stalls.
// ----------------------------------------------------------------------------
module tb_percent_escape_normalizer;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 5;
  localparam int MAX_OUT        = 5;
  localparam int RANDOM_ITEMS   = 350;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int DRAIN_CYCLES   = 32;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int MAX_REPORTS    = 10;
  localparam int DELIM_COUNT    = 18;

  localparam logic [7:0] PCT = "%";
  localparam logic [DELIM_COUNT*8-1:0] DELIM_SET = ":/?#[]@!$&'()*+,;=";

  typedef enum logic [2:0] {
    TOK_ESC,
    TOK_PRINTABLE,
    TOK_DELIM,
    TOK_PCT,
    TOK_RAW
  } tok_kind_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte    = '0;
  logic       in_is_last = 1'b0;
  logic       out_valid;
  logic       out_stall  = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;

  out_beat_t  pending_norm_bytes [$];
  out_beat_t  exp_beat;
  logic [7:0] held_q [2];
  int         held_n      = 0;
  int         err_count   = 0;
  int         items_sent  = 0;
  int         cycle_count = 0;
  int         burst_left  = 0;
  bit         pacing_on   = 1'b0;
  logic [15:0] stall_pat  = '0;
  logic [3:0] pat_pos     = '0;
  int         holdoff_cnt = 0;
  int         holdoff_len = 0;

  percent_escape_normalizer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_is_last(in_is_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  function automatic logic is_unres_ch(input logic [7:0] v);
    return (v >= "a" && v <= "z") || (v >= "A" && v <= "Z") ||
           (v >= "0" && v <= "9") || v == "-" || v == "." || v == "_" || v == "~";
  endfunction

  function automatic logic is_delim_ch(input logic [7:0] v);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < DELIM_COUNT; k++) begin
      if (DELIM_SET[8*k +: 8] == v) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic is_hex_ch(input logic [7:0] v);
    return (v >= "0" && v <= "9") || (v >= "A" && v <= "F") || (v >= "a" && v <= "f");
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] r;
    if (c <= "9") begin
      r = c - "0";
    end else if (c <= "F") begin
      r = c - "A" + 8'd10;
    end else begin
      r = c - "a" + 8'd10;
    end
    return r[3:0];
  endfunction

  function automatic logic [7:0] hex_digit_ch(input logic [3:0] d, input logic lower);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = "0" + {4'h0, d};
    end else if (lower) begin
      r = "a" + {4'h0, d} - 8'd10;
    end else begin
      r = "A" + {4'h0, d} - 8'd10;
    end
    return r;
  endfunction

  // Works out the output beats of one input byte and updates the held bytes.
  task automatic normalize_beat(input logic [7:0] b, input logic lst);
    logic [7:0] win [3];
    logic [7:0] emit_q [$];
    logic [7:0] c;
    logic [7:0] v;
    logic       plain;
    int         n;
    int         i;
    int         adv;
    out_beat_t  beat;
    n = 0;
    i = 0;
    for (int j = 0; j < held_n; j++) begin
      win[n] = held_q[j];
      n++;
    end
    win[n] = b;
    n++;
    while (i < n) begin
      c = win[i];
      if (c == PCT && n - i >= 3 && is_hex_ch(win[i + 1]) && is_hex_ch(win[i + 2])) begin
        v     = {nibble_of(win[i + 1]), nibble_of(win[i + 2])};
        plain = is_unres_ch(v);
        adv   = 3;
      end else if (c == PCT && n - i < 3 && !lst) begin
        break;
      end else begin
        v     = c;
        plain = (c == PCT) || is_delim_ch(c) || is_unres_ch(c);
        adv   = 1;
      end
      if (plain) begin
        emit_q.push_back(v);
      end else begin
        emit_q.push_back(PCT);
        emit_q.push_back(hex_digit_ch(v[7:4], 1'b0));
        emit_q.push_back(hex_digit_ch(v[3:0], 1'b0));
      end
      i += adv;
    end
    held_n = 0;
    while (i < n && held_n < 2) begin
      held_q[held_n] = win[i];
      held_n++;
      i++;
    end
    for (int k = 0; k < emit_q.size() && k < MAX_OUT; k++) begin
      beat.data = emit_q[k];
      beat.last = lst && (k == emit_q.size() - 1 || k == MAX_OUT - 1);
      pending_norm_bytes.push_back(beat);
    end
  endtask

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("%0t mismatch: %s", $time, msg);
  endtask

  // A beat is committed once stall is seen low at the falling edge.
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_norm_bytes.size() == 0) begin
        flag_error($sformatf("unexpected beat byte=%02h last=%0b", out_byte, out_last));
      end else begin
        exp_beat = pending_norm_bytes.pop_front();
        if (out_byte !== exp_beat.data) begin
          flag_error($sformatf("out_byte expected %02h actual %02h", exp_beat.data, out_byte));
        end
        if (out_last !== exp_beat.last) begin
          flag_error($sformatf("out_last expected %0b actual %0b", exp_beat.last, out_last));
        end
      end
    end
  end

  function automatic logic [15:0] next_stall_pattern();
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] r;
    a = 16'($urandom);
    b = 16'($urandom);
    case ($urandom_range(0, 3))
      0: r = 16'h0000;
      1: r = a;
      2: r = a & b;
      default: r = a | b;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (holdoff_cnt != 0) begin
      out_stall   <= 1'b1;
      holdoff_cnt <= holdoff_cnt - 1;
    end else if (holdoff_len != 0) begin
      out_stall   <= 1'b1;
      holdoff_cnt <= holdoff_len;
      holdoff_len = 0;
    end else begin
      out_stall <= stall_pat[pat_pos];
      pat_pos   <= pat_pos + 4'd1;
      if (pat_pos == 4'hF) stall_pat <= next_stall_pattern();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic lst);
    in_valid   <= 1'b1;
    in_byte    <= b;
    in_is_last <= lst;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    normalize_beat(b, lst);
    @(posedge clk);
    items_sent++;
  endtask

  task automatic sender_pause();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  function automatic tok_kind_t pick_kind();
    int r;
    tok_kind_t k;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      k = TOK_ESC;
    end else if (r < 60) begin
      k = TOK_PRINTABLE;
    end else if (r < 75) begin
      k = TOK_DELIM;
    end else if (r < 85) begin
      k = TOK_PCT;
    end else begin
      k = TOK_RAW;
    end
    return k;
  endfunction

  // Sends one component of at least len bytes, the final byte flagged last.
  task automatic send_uri_part(input int len);
    logic [7:0] part_q [$];
    logic [7:0] v;
    int         idx;
    while (part_q.size() < len) begin
      v = 8'($urandom_range(0, 255));
      case (pick_kind())
        TOK_ESC: begin
          if ($urandom_range(0, 1)) v = 8'($urandom_range(8'h20, 8'h7E));
          part_q.push_back(PCT);
          part_q.push_back(hex_digit_ch(v[7:4], 1'($urandom_range(0, 1))));
          if ($urandom_range(0, 9) == 0) begin
            v = 8'("G" + $urandom_range(0, 19));
            part_q.push_back(v);
          end else begin
            part_q.push_back(hex_digit_ch(v[3:0], 1'($urandom_range(0, 1))));
          end
        end
        TOK_PRINTABLE: begin
          v = 8'($urandom_range(8'h21, 8'h7E));
          part_q.push_back(v);
        end
        TOK_DELIM: begin
          idx = $urandom_range(0, DELIM_COUNT - 1);
          part_q.push_back(DELIM_SET[8*idx +: 8]);
        end
        TOK_PCT: part_q.push_back(PCT);
        default: part_q.push_back(v);
      endcase
    end
    foreach (part_q[k]) begin
      send_byte(part_q[k], k == part_q.size() - 1);
      if (pacing_on) sender_pause();
    end
  endtask

  task automatic test_directed();
    pacing_on = 1'b0;
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte("%", 1'b0);
    send_byte("4", 1'b0);
    send_byte("1", 1'b1);
    send_byte("%", 1'b0);
    send_byte("2", 1'b0);
    send_byte("f", 1'b1);
    send_byte("%", 1'b0);
    send_byte("7", 1'b0);
    send_byte("e", 1'b1);
    send_byte("%", 1'b0);
    send_byte("G", 1'b0);
    send_byte("1", 1'b1);
    send_byte("%", 1'b0);
    send_byte("4", 1'b1);
    send_byte("%", 1'b1);
    send_byte("a", 1'b0);
    send_byte(" ", 1'b0);
    send_byte("/", 1'b1);
    send_byte("%", 1'b0);
    send_byte("%", 1'b0);
    send_byte("4", 1'b0);
    send_byte("1", 1'b1);
    send_byte("%", 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h81, 1'b1);
  endtask

  task automatic test_input_backpressure();
    pacing_on   = 1'b0;
    holdoff_len = HOLDOFF_CYCLES;
    send_uri_part(30);
  endtask

  task automatic test_drain_pause();
    pacing_on = 1'b1;
    for (int p = 0; p < 4; p++) begin
      send_uri_part($urandom_range(1, 6));
      in_valid <= 1'b0;
      while (pending_norm_bytes.size() != 0) @(posedge clk);
      @(posedge clk);
    end
  endtask

  task automatic test_random_parts();
    int start;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      pacing_on = ($urandom_range(0, 3) != 0);
      send_uri_part($urandom_range(1, 10));
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_input_backpressure();
    test_drain_pause();
    test_random_parts();
    in_valid <= 1'b0;
    while (pending_norm_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ percent_escape_normalizer.f @@
hdl/pen_pkg.sv
hdl/pen_front.sv
hdl/pen_queue.sv
hdl/pen_back.sv
hdl/percent_escape_normalizer.sv
hdl/pen_checker.sv
sim/tb_percent_escape_normalizer.sv
